// ----- sv/sms_pkg.sv -----
// Shared transaction types for the subarray minimum sum block.
`default_nettype none

package sms_pkg;

    // Input transaction: one array element.
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } t_in;

    // Output transaction: one result per array.
    typedef struct packed {
        logic signed [63:0] total;
        logic               overflow;
    } t_out;

    // Classified element as it travels from the front end to the stack engine.
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
        logic               keep;      // element is inside capacity
        logic               overflow;  // capacity exceeded so far, valid with last
    } t_q_item;

endpackage

`default_nettype wire

// ----- sv/sms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/sms_queue.sv -----
// Short FIFO between the front end and the stack engine.
`default_nettype none

module sms_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire sms_pkg::t_q_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output sms_pkg::t_q_item     o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    sms_pkg::t_q_item r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [NW-1:0]    r_cnt,  n_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (w_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(DEPTH))
        else $error("queue fill count above depth");

endmodule

`default_nettype wire

// ----- sv/sms_front.sv -----
// Front end: accepts elements, applies the capacity limit, feeds the queue.
`default_nettype none

module sms_front #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire sms_pkg::t_in     i_in_data,
    output logic                  o_in_stall,
    input  wire logic             i_q_full,
    output logic                  o_q_push,
    output sms_pkg::t_q_item      o_q_item
);

    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_ovf,   n_ovf;
    logic          w_keep;
    logic          w_ovf_now;

    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;
    assign w_keep     = (r_count < CW'(MAX_LEN));
    assign w_ovf_now  = r_ovf || !w_keep;

    always_comb begin
        o_q_item.value    = i_in_data.value;
        o_q_item.last     = i_in_data.last;
        o_q_item.keep     = w_keep;
        o_q_item.overflow = w_ovf_now;
    end

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (o_q_push) begin
            if (i_in_data.last) begin
                // end of array: start the next one from scratch
                n_count = '0;
                n_ovf   = 1'b0;
            end else begin
                n_count = w_keep ? r_count + CW'(1) : r_count;
                n_ovf   = w_ovf_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

endmodule

`default_nettype wire

// ----- sv/sms_back.sv -----
// Stack engine: monotonic stack of (value, run), ending sum, total, result register.
`default_nettype none

module sms_back #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire sms_pkg::t_q_item i_q_item,
    output logic                  o_q_pop,
    output logic                  o_out_valid,
    output sms_pkg::t_out         o_out_data,
    input  wire logic             i_out_stall
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int EW = 32 + CW;
    localparam int RW = 32 + CW;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CMP  = 6'b000010,
        S_POP  = 6'b000100,
        S_PUSH = 6'b001000,
        S_ACC  = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic signed [31:0]   r_x, n_x;
    logic                 r_last, n_last;
    logic                 r_ovf, n_ovf;
    logic [CW-1:0]        r_run, n_run;
    logic [CW-1:0]        r_depth, n_depth;
    logic signed [31:0]   r_top_val, n_top_val;
    logic [CW-1:0]        r_top_cnt, n_top_cnt;
    logic signed [EW-1:0] r_prod, n_prod;
    logic signed [EW-1:0] r_end, n_end;
    logic [63:0]          r_total, n_total;
    logic                 r_out_valid, n_out_valid;
    sms_pkg::t_out        r_out, n_out;

    logic                 w_pop_hit;
    logic                 w_out_free;
    logic signed [31:0]   w_mul_a;
    logic [CW-1:0]        w_mul_b;
    logic signed [32+CW:0] w_mul;
    logic [CW-1:0]        w_rd_idx, w_wr_idx;
    logic                 w_we;
    logic [RW-1:0]        w_rdata;

    assign w_pop_hit  = (r_depth != '0) && (r_top_val >= r_x);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_mul_a    = w_pop_hit ? r_top_val : r_x;
    assign w_mul_b    = w_pop_hit ? r_top_cnt : r_run;
    assign w_mul      = w_mul_a * $signed({1'b0, w_mul_b});
    assign w_rd_idx   = r_depth - CW'(2);
    assign w_wr_idx   = r_depth - CW'(1);
    assign w_we       = (r_state == S_CMP) && !w_pop_hit && (r_depth != '0);
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Entries below the top live in RAM; the top entry is held in registers.
    sms_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_LEN)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wr_idx[AW-1:0]),
        .i_wdata ({r_top_val, r_top_cnt}),
        .i_raddr (w_rd_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_last      = r_last;
        n_ovf       = r_ovf;
        n_run       = r_run;
        n_depth     = r_depth;
        n_top_val   = r_top_val;
        n_top_cnt   = r_top_cnt;
        n_prod      = r_prod;
        n_end       = r_end;
        n_total     = r_total;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_x    = i_q_item.value;
                    n_last = i_q_item.last;
                    n_ovf  = i_q_item.overflow;
                    n_run  = CW'(1);
                    if (i_q_item.keep) begin
                        n_state = S_CMP;
                    end else if (i_q_item.last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_CMP: begin
                n_prod = w_mul[EW-1:0];
                if (w_pop_hit) begin
                    // drop the top entry, merge its run into the new one
                    n_run   = r_run + r_top_cnt;
                    n_depth = r_depth - CW'(1);
                    n_state = S_POP;
                end else begin
                    n_top_val = r_x;
                    n_top_cnt = r_run;
                    n_depth   = r_depth + CW'(1);
                    n_state   = S_PUSH;
                end
            end
            S_POP: begin
                n_end = r_end - r_prod;
                if (r_depth != '0) begin
                    n_top_val = w_rdata[RW-1:CW];
                    n_top_cnt = w_rdata[CW-1:0];
                end
                n_state = S_CMP;
            end
            S_PUSH: begin
                n_end   = r_end + r_prod;
                n_state = S_ACC;
            end
            S_ACC: begin
                n_total = r_total + {{(64 - EW){r_end[EW-1]}}, r_end};
                n_state = r_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out.total    = r_total;
                    n_out.overflow = r_ovf;
                    n_out_valid    = 1'b1;
                    n_depth        = '0;
                    n_end          = '0;
                    n_total        = '0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_end       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_end       <= n_end;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_last    <= n_last;
        r_ovf     <= n_ovf;
        r_run     <= n_run;
        r_top_val <= n_top_val;
        r_top_cnt <= n_top_cnt;
        r_prod    <= n_prod;
        r_out     <= n_out;
    end

    a_depth_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CW'(MAX_LEN))
        else $error("stack depth above capacity");

    a_pop_follows_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> ($past(r_state) == S_CMP))
        else $error("pop step without a compare");

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free) |=> (r_depth == '0 && r_total == '0
            && r_out_valid))
        else $error("state not cleared after result");

endmodule

`default_nettype wire

// ----- sv/subarray_minimum_sum.sv -----
// Top level: sum of subarray minimums over a streamed array.
//
// Input channel: i_in_valid / o_in_stall carry one signed 32-bit element per
// transaction with a last mark on the final element of the array. Output
// channel: o_out_valid / i_out_stall carry one transaction per array, the
// 64-bit total and an overflow flag, on the element that carries last.
// Elements past MAX_LEN are dropped and set the overflow flag.
// Timing: the front end passes each accepted element straight to the queue.
// The stack engine then steps through take, compare, push and accumulate for
// each kept element, plus compare and subtract with RAM read for each stack
// entry it pops; the stack RAM's registered read and the shared multiplier set
// this. Each element is popped at most once. A dropped element is only taken,
// and last adds an emit step that loads the result register for o_out_valid
// once the engine has worked off the elements queued ahead of it.
// Reset (synchronous, active low) empties the queue and the stack; the stack
// RAM needs no clearing. After a result is loaded all state clears for the
// next array. While the receiver stalls, the result holds; the engine keeps
// working on the next array and waits only when a second result is ready.
`default_nettype none

module subarray_minimum_sum #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire sms_pkg::t_in  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output sms_pkg::t_out      o_out_data,
    input  wire logic          i_out_stall
);

    localparam int QDEPTH = 4;

    logic             w_q_push;
    logic             w_q_full;
    logic             w_q_pop;
    logic             w_q_valid;
    sms_pkg::t_q_item w_q_in;
    sms_pkg::t_q_item w_q_out;

    // Classify each transaction against capacity and queue it.
    sms_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_item   (w_q_in)
    );

    // Decouple intake from the variable-length stack work.
    sms_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_out)
    );

    // Run the monotonic stack and hold the result until it is taken.
    sms_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_out),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// ----- tb/subarray_minimum_sum_test.sv -----
// Testbench for the subarray minimum sum block: directed and random arrays.
`default_nettype none

module subarray_minimum_sum_test;

    // Capacity of the block under test, and of the predictor's stack.
    localparam int MAX_LEN = 1024;

    // Random arrays stop once this many elements have been sent.
    localparam int RANDOM_ITEMS = 200;

    // Watchdog. The slowest correct run sends roughly 1330 elements, plus gaps
    // and output stalls.
    localparam int CYCLE_LIMIT = 400000;

    // Both sides run without gaps or stalls inside this cycle window.
    localparam int QUIET_FROM = 5000;
    localparam int QUIET_TO   = 15000;

    // Cycles to watch for stray results once nothing is pending.
    localparam int DRAIN_CYCLES = 64;

    localparam logic signed [31:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'h7fff_ffff;

    // Value styles for the random arrays.
    typedef enum int {
        STYLE_FULL,      // any 32-bit value
        STYLE_TIES,      // a handful of small values, many equal neighbors
        STYLE_EXTREME,   // corner values only
        STYLE_MIXED      // style picked again per element
    } t_style;

    // One row of the directed stimulus. Where has_typed is set, the result
    // in the row is the one checked; otherwise the predictor decides.
    typedef struct {
        logic signed [31:0] value;
        bit                 last;
        bit                 has_typed;
        longint             total;
        bit                 overflow;
    } t_step;

    localparam int NUM_STEPS = 22;

    t_step steps [NUM_STEPS] = '{
        // Single-element arrays: the total is the element itself.
        '{VAL_MIN,  1'b1, 1'b1, -64'sd2147483648, 1'b0},
        '{VAL_MAX,  1'b1, 1'b1,  64'sd2147483647, 1'b0},
        '{32'sd0,   1'b1, 1'b1,  64'sd0,          1'b0},
        // Textbook case 3,1,2,4: minimums sum to 17.
        '{32'sd3,   1'b0, 1'b0,  64'sd0,          1'b0},
        '{32'sd1,   1'b0, 1'b0,  64'sd0,          1'b0},
        '{32'sd2,   1'b0, 1'b0,  64'sd0,          1'b0},
        '{32'sd4,   1'b1, 1'b1,  64'sd17,         1'b0},
        // Equal values merge on the stack: six subarrays of minimum 2.
        '{32'sd2,   1'b0, 1'b0,  64'sd0,          1'b0},
        '{32'sd2,   1'b0, 1'b0,  64'sd0,          1'b0},
        '{32'sd2,   1'b1, 1'b1,  64'sd12,         1'b0},
        // Strictly falling: every element pops its predecessor.
        '{32'sd5,   1'b0, 1'b0,  64'sd0,          1'b0},
        '{32'sd4,   1'b0, 1'b0,  64'sd0,          1'b0},
        '{32'sd3,   1'b1, 1'b1,  64'sd22,         1'b0},
        // Largest magnitudes, tied: three subarrays each.
        '{VAL_MAX,  1'b0, 1'b0,  64'sd0,          1'b0},
        '{VAL_MAX,  1'b1, 1'b1,  64'sd6442450941, 1'b0},
        '{VAL_MIN,  1'b0, 1'b0,  64'sd0,          1'b0},
        '{VAL_MIN,  1'b1, 1'b1, -64'sd6442450944, 1'b0},
        // Sign change: -1, 1, then min(-1,1).
        '{-32'sd1,  1'b0, 1'b0,  64'sd0,          1'b0},
        '{32'sd1,   1'b1, 1'b1, -64'sd1,          1'b0},
        // Valley shape, left to the predictor.
        '{32'sd7,   1'b0, 1'b0,  64'sd0,          1'b0},
        '{-32'sd3,  1'b0, 1'b0,  64'sd0,          1'b0},
        '{32'sd7,   1'b1, 1'b0,  64'sd0,          1'b0}
    };

    // DUT connections; every input is known from time zero.
    logic          i_clk      = 1'b0;
    logic          i_rst_n    = 1'b0;
    logic          in_valid   = 1'b0;
    sms_pkg::t_in  in_data    = '0;
    logic          out_stall  = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    sms_pkg::t_out o_out_data;

    int cycle_cnt    = 0;
    int mismatch_cnt = 0;

    // Predictor state: monotonic stack of (value, run length) entries.
    logic signed [31:0] stk_val [MAX_LEN];
    int unsigned        stk_run [MAX_LEN];
    int unsigned        stk_depth     = 0;
    int unsigned        elem_cnt      = 0;
    longint             ending_sum    = 0;
    longint             grand_total   = 0;
    bit                 capacity_hit  = 1'b0;

    // Results still owed by the block, oldest first.
    sms_pkg::t_out expected_totals [$];

    subarray_minimum_sum #(
        .MAX_LEN(MAX_LEN)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(out_stall)
    );

    always #10 i_clk = ~i_clk;

    // Count cycles and bail out if the block hangs.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Decide whether a side idles this cycle: about 7 in 100, never inside
    // the quiet window.
    function automatic bit take_gap();
        if (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO)
            return 1'b0;
        return $urandom_range(99) < 7;
    endfunction

    // Advance the predictor by one element. Return 1 and the result when
    // the element closes an array; the state then clears for the next one.
    function automatic bit predict_minimum_sum(input sms_pkg::t_in item,
                                               output sms_pkg::t_out res);
        longint      x;
        int unsigned run;
        x   = longint'($signed(item.value));
        res = '0;
        if (elem_cnt < MAX_LEN) begin
            run = 1;
            // Pop entries that are not strictly smaller; their subarrays now
            // end on x as their minimum.
            while (stk_depth > 0 && longint'(stk_val[stk_depth - 1]) >= x) begin
                stk_depth--;
                ending_sum -= longint'(stk_val[stk_depth]) * longint'(stk_run[stk_depth]);
                run += stk_run[stk_depth];
            end
            stk_val[stk_depth] = item.value;
            stk_run[stk_depth] = run;
            stk_depth++;
            ending_sum  += x * longint'(run);
            grand_total += ending_sum;
            elem_cnt++;
        end else begin
            // Past capacity: drop the element, remember it.
            capacity_hit = 1'b1;
        end
        if (!item.last)
            return 1'b0;
        res.total    = grand_total;
        res.overflow = capacity_hit;
        stk_depth    = 0;
        elem_cnt     = 0;
        ending_sum   = 0;
        grand_total  = 0;
        capacity_hit = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0d] mismatch: %s", cycle_cnt, msg);
        mismatch_cnt++;
    endtask

    // Offer one element at the falling edge, hold it until the block takes
    // it, then queue whatever result it closes. Return at a falling edge.
    task automatic send_element(input sms_pkg::t_in item, input bit has_typed,
                                input sms_pkg::t_out typed);
        sms_pkg::t_out predicted;
        while (take_gap()) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (predict_minimum_sum(item, predicted))
            expected_totals.push_back(has_typed ? typed : predicted);
        @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] random_element(input t_style style);
        t_style pick;
        pick = style;
        if (pick == STYLE_MIXED)
            pick = t_style'($urandom_range(STYLE_EXTREME));
        case (pick)
            STYLE_TIES: begin
                return $signed($urandom_range(6)) - 32'sd3;
            end
            STYLE_EXTREME: begin
                case ($urandom_range(3))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    // Output side: stall at random, released at the falling edge.
    always @(negedge i_clk)
        out_stall <= take_gap();

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        sms_pkg::t_out want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_totals.size() == 0) begin
                report_mismatch($sformatf("unexpected result total=%0d overflow=%0b",
                                          o_out_data.total, o_out_data.overflow));
            end else begin
                want = expected_totals.pop_front();
                if (o_out_data.total !== want.total)
                    report_mismatch($sformatf("total %0d, want %0d",
                                              o_out_data.total, want.total));
                if (o_out_data.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow %0b, want %0b",
                                              o_out_data.overflow, want.overflow));
            end
        end
    end

    initial begin
        sms_pkg::t_in  item;
        sms_pkg::t_out typed;
        t_style        style;
        int            len;
        int            random_sent;

        // Hold reset, release at a falling edge.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows.
        for (int i = 0; i < NUM_STEPS; i++) begin
            item.value     = steps[i].value;
            item.last      = steps[i].last;
            typed.total    = steps[i].total;
            typed.overflow = steps[i].overflow;
            send_element(item, steps[i].has_typed, typed);
        end
        typed = '0;

        // Full capacity, strictly rising: the stack fills to MAX_LEN - 1,
        // then VAL_MIN, at or below every entry, pops them all. Three
        // more elements follow past capacity and are dropped, and the last
        // mark arrives on a dropped element.
        for (int i = 0; i < MAX_LEN + 3; i++) begin
            if (i < MAX_LEN - 1)
                item.value = VAL_MIN + i * 32'sh0020_0000 + $urandom_range(32'h001f_ffff);
            else if (i == MAX_LEN - 1)
                item.value = VAL_MIN;
            else
                item.value = random_element(STYLE_MIXED);
            item.last = (i == MAX_LEN + 2);
            send_element(item, 1'b0, typed);
        end

        // Random arrays, mostly short.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            len   = ($urandom_range(99) < 85) ? $urandom_range(1, 12)
                                              : $urandom_range(13, 80);
            style = t_style'($urandom_range(STYLE_MIXED));
            for (int i = 0; i < len; i++) begin
                item.value = random_element(style);
                item.last  = (i == len - 1);
                send_element(item, 1'b0, typed);
            end
            random_sent += len;
        end
        in_valid <= 1'b0;

        // Wait for every owed result, then watch for strays.
        while (expected_totals.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
